[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for clocked checks with async reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lzsd_pkg.sv]
// ----------------------------------------------------------------------------
// lzsd_pkg
// Types and constants shared by the LZSS decompressor modules.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WIN_BITS    = 10;
    localparam int WINDOW_SIZE = 1 << WIN_BITS;
    localparam int MLEN_BITS   = 7;

    localparam logic [WIN_BITS-1:0]  WINDOW_START_RESET = 10'h3BE;
    localparam logic [7:0]           FLAG_FILL          = 8'hFF;
    localparam logic [MLEN_BITS-1:0] MATCH_LEN_BIAS     = 7'd3;

    localparam logic [1:0] REG_OUTPUT_LENGTH = 2'd0;
    localparam logic [1:0] REG_WINDOW_START  = 2'd1;

    typedef enum logic [1:0] {
        OP_START,
        OP_LITERAL,
        OP_MATCH
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [WIN_BITS-1:0]  data;
        logic [MLEN_BITS-1:0] len;
        logic                 done;
    } cmd_t;

endpackage

[rtl/lzsd_front.sv]
// ----------------------------------------------------------------------------
// lzsd_front
// Token parser: holds config, tracks flags and remaining length, and issues
// start, literal and match commands.
// ----------------------------------------------------------------------------
module lzsd_front import lzsd_pkg::*; #(
    parameter int LENGTH_BITS = 24,
    parameter int CFG_WIDTH   = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 stream_start,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 q_full,
    output logic                 cmd_push,
    output cmd_t                 cmd
);

    localparam logic [1:0] PH_FLAG   = 2'd0;
    localparam logic [1:0] PH_TOKEN  = 2'd1;
    localparam logic [1:0] PH_MATCH2 = 2'd2;

    logic [LENGTH_BITS-1:0] out_len_reg;
    logic [WIN_BITS-1:0]    win_start_reg;
    logic [15:0]            flags_reg, flags_next;
    logic [1:0]             phase_reg, phase_next;
    logic [7:0]             pol_reg, pol_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    logic                   accept;
    logic [MLEN_BITS-1:0]   mlen;
    logic [LENGTH_BITS-1:0] mlen_ext;
    logic [15:0]            flags_shift;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        flags_next  = flags_reg;
        phase_next  = phase_reg;
        pol_next    = pol_reg;
        rem_next    = rem_reg;
        cmd_push    = 1'b0;
        cmd.op      = OP_START;
        cmd.data    = win_start_reg;
        cmd.len     = '0;
        cmd.done    = 1'b0;
        mlen        = {1'b0, in_byte[5:0]} + MATCH_LEN_BIAS;
        mlen_ext    = LENGTH_BITS'(mlen);
        flags_shift = {1'b0, flags_reg[15:1]};

        if (accept)
        begin
            if (stream_start)
            begin
                flags_next = '0;
                phase_next = PH_FLAG;
                pol_next   = '0;
                rem_next   = out_len_reg;
                cmd_push   = 1'b1;
            end
            if (rem_next != '0)
            begin
                unique case (phase_next)
                    PH_TOKEN:
                    begin
                        if (flags_next[0])
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_LITERAL;
                            cmd.data = WIN_BITS'(in_byte);
                            cmd.len  = MLEN_BITS'(1);
                            rem_next = rem_next - LENGTH_BITS'(1);
                            cmd.done = (rem_next == '0);
                            if (!cmd.done)
                            begin
                                flags_next = flags_shift;
                                phase_next = flags_shift[8] ? PH_TOKEN : PH_FLAG;
                            end
                        end
                        else
                        begin
                            pol_next   = in_byte;
                            phase_next = PH_MATCH2;
                        end
                    end
                    PH_MATCH2:
                    begin
                        cmd_push = 1'b1;
                        cmd.op   = OP_MATCH;
                        cmd.data = {in_byte[7:6], pol_reg};
                        if (mlen_ext >= rem_next)
                        begin
                            cmd.len  = rem_next[MLEN_BITS-1:0];
                            cmd.done = 1'b1;
                            rem_next = '0;
                        end
                        else
                        begin
                            cmd.len    = mlen;
                            rem_next   = rem_next - mlen_ext;
                            flags_next = flags_shift;
                            phase_next = flags_shift[8] ? PH_TOKEN : PH_FLAG;
                        end
                    end
                    default:
                    begin
                        flags_next = {FLAG_FILL, in_byte};
                        phase_next = PH_TOKEN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_len_reg   <= '0;
            win_start_reg <= WINDOW_START_RESET;
            flags_reg     <= '0;
            phase_reg     <= PH_FLAG;
            pol_reg       <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            phase_reg <= phase_next;
            pol_reg   <= pol_next;
            rem_reg   <= rem_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OUTPUT_LENGTH: out_len_reg   <= cfg_data[LENGTH_BITS-1:0];
                    REG_WINDOW_START:  win_start_reg <= cfg_data[WIN_BITS-1:0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

[rtl/lzsd_fifo.sv]
// ----------------------------------------------------------------------------
// lzsd_fifo
// Small command queue between parser and copy engine.
// ----------------------------------------------------------------------------
module lzsd_fifo import lzsd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/lzsd_back.sv]
// ----------------------------------------------------------------------------
// lzsd_back
// Copy engine: owns the history ring, writes literals, copies matches one
// byte per cycle unless output stalls, and packs bytes into two-byte words.
// ----------------------------------------------------------------------------
module lzsd_back import lzsd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_first,
    output logic [7:0] byte_second,
    output logic [1:0] byte_count,
    output logic       run_last,
    output logic       stream_done
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MATCH = 1'b1;

    logic [7:0] ring [WINDOW_SIZE];
    logic [7:0] ring_q;

    logic                 state_reg, state_next;
    logic [WIN_BITS-1:0]  src_reg, src_next;
    logic [MLEN_BITS-1:0] cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic                 mdone_reg, mdone_next;
    logic [WIN_BITS-1:0]  wp_reg, wp_next;
    logic [WIN_BITS-1:0]  base_reg, base_next;
    logic [WIN_BITS:0]    fill_reg, fill_next;
    logic                 fwd_reg, fwd_next;
    logic [7:0]           fwd_data_reg, fwd_data_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic                 hold_reg, hold_next;
    logic [7:0]           hold_data_reg, hold_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           first_reg, first_next;
    logic [7:0]           second_reg, second_next;
    logic [1:0]           count_reg, count_next;
    logic                 last_reg, last_next;
    logic                 done_reg, done_next;

    logic                slot_free;
    logic                byte_go;
    logic [7:0]          byte_val;
    logic                byte_last;
    logic                byte_done;
    logic                ring_re;
    logic [WIN_BITS-1:0] rel;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        mdone_next     = mdone_reg;
        wp_next        = wp_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        rd_ok_next     = rd_ok_reg;
        hold_next      = hold_reg;
        hold_data_next = hold_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        first_next     = first_reg;
        second_next    = second_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        cmd_pop        = 1'b0;
        byte_go        = 1'b0;
        byte_val       = '0;
        byte_last      = 1'b0;
        byte_done      = 1'b0;
        ring_re        = 1'b0;
        rel            = src_reg - base_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_START:
                        begin
                            cmd_pop   = 1'b1;
                            wp_next   = cmd.data;
                            base_next = cmd.data;
                            fill_next = '0;
                        end
                        OP_LITERAL:
                        begin
                            if (slot_free)
                            begin
                                cmd_pop   = 1'b1;
                                byte_go   = 1'b1;
                                byte_val  = cmd.data[7:0];
                                byte_last = 1'b1;
                                byte_done = cmd.done;
                            end
                        end
                        OP_MATCH:
                        begin
                            cmd_pop    = 1'b1;
                            src_next   = cmd.data;
                            cnt_next   = cmd.len;
                            pend_next  = 1'b0;
                            mdone_next = cmd.done;
                            state_next = ST_MATCH;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_MATCH:
            begin
                if (slot_free)
                begin
                    if (pend_reg)
                    begin
                        byte_go   = 1'b1;
                        byte_val  = fwd_reg ? fwd_data_reg : (rd_ok_reg ? ring_q : 8'h00);
                        byte_last = (cnt_reg == '0);
                        byte_done = byte_last && mdone_reg;
                        if (byte_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    if (cnt_reg != '0)
                    begin
                        ring_re   = 1'b1;
                        src_next  = src_reg + 1'b1;
                        cnt_next  = cnt_reg - 1'b1;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (byte_go)
        begin
            wp_next   = wp_reg + 1'b1;
            fill_next = fill_reg[WIN_BITS] ? fill_reg : fill_reg + 1'b1;
            if (hold_reg)
            begin
                out_valid_next = 1'b1;
                first_next     = hold_data_reg;
                second_next    = byte_val;
                count_next     = 2'd2;
                last_next      = byte_last;
                done_next      = byte_done;
                hold_next      = 1'b0;
            end
            else if (byte_last)
            begin
                out_valid_next = 1'b1;
                first_next     = byte_val;
                second_next    = 8'h00;
                count_next     = 2'd1;
                last_next      = 1'b1;
                done_next      = byte_done;
            end
            else
            begin
                hold_next      = 1'b1;
                hold_data_next = byte_val;
            end
        end

        if (ring_re)
        begin
            fwd_next      = byte_go && (wp_reg == src_reg);
            fwd_data_next = byte_val;
            rd_ok_next    = fill_next[WIN_BITS] || ({1'b0, rel} < fill_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_go)
        begin
            ring[wp_reg] <= byte_val;
        end
        if (ring_re)
        begin
            ring_q <= ring[src_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            src_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            mdone_reg     <= 1'b0;
            wp_reg        <= WINDOW_START_RESET;
            base_reg      <= WINDOW_START_RESET;
            fill_reg      <= '0;
            fwd_reg       <= 1'b0;
            fwd_data_reg  <= '0;
            rd_ok_reg     <= 1'b0;
            hold_reg      <= 1'b0;
            hold_data_reg <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            mdone_reg     <= mdone_next;
            wp_reg        <= wp_next;
            base_reg      <= base_next;
            fill_reg      <= fill_next;
            fwd_reg       <= fwd_next;
            fwd_data_reg  <= fwd_data_next;
            rd_ok_reg     <= rd_ok_next;
            hold_reg      <= hold_next;
            hold_data_reg <= hold_data_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            done_reg      <= done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_first  = first_reg;
    assign byte_second = second_reg;
    assign byte_count  = count_reg;
    assign run_last    = last_reg;
    assign stream_done = done_reg;

endmodule

[rtl/lzss_ring_decompressor.sv]
// ----------------------------------------------------------------------------
// lzss_ring_decompressor
// LZSS decompressor with a 1K history ring and two-byte output words.
// ----------------------------------------------------------------------------
// The parser takes one compressed byte per cycle while its command queue has
// room; flag bytes and first match bytes end there. The copy engine writes a
// literal to the ring and sends it out. For a match of length L it takes the
// command, primes the single read port of the ring, then copies the history
// bytes in turn and takes no new command until the match is done. Bytes leave
// paired into two-byte words, so a match of L bytes gives ceil(L/2) words.
// Entries not yet written in the current stream read as zero through a fill
// count kept against the stream base, so a stream start needs no clearing
// sweep of the ring.
`include "assert_macros.svh"

module lzss_ring_decompressor import lzsd_pkg::*; #(
    parameter int LENGTH_BITS = 24,
    parameter int QUEUE_DEPTH = 4,
    localparam int CFG_WIDTH  = (LENGTH_BITS > WIN_BITS) ? LENGTH_BITS : WIN_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 stream_start,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           byte_first,
    output logic [7:0]           byte_second,
    output logic [1:0]           byte_count,
    output logic                 run_last,
    output logic                 stream_done
);

    logic cmd_push;
    cmd_t cmd_in;
    logic q_full;
    logic q_empty;
    logic cmd_pop;
    cmd_t cmd_head;

    lzsd_front #(
        .LENGTH_BITS (LENGTH_BITS),
        .CFG_WIDTH   (CFG_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .stream_start (stream_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    lzsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .full     (q_full),
        .pop      (cmd_pop),
        .empty    (q_empty),
        .head     (cmd_head)
    );

    lzsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (!q_empty),
        .cmd         (cmd_head),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_first  (byte_first),
        .byte_second (byte_second),
        .byte_count  (byte_count),
        .run_last    (run_last),
        .stream_done (stream_done)
    );

    `ASSERT_IMPLIES(a_count_range, clk, rst_n, out_valid, byte_count == 2'd1 || byte_count == 2'd2, "word with bad byte count")
    `ASSERT_IMPLIES(a_single_pad, clk, rst_n, out_valid && byte_count == 2'd1, byte_second == 8'h00 && run_last, "single-byte word not padded or not last")
    `ASSERT_IMPLIES(a_done_last, clk, rst_n, out_valid && stream_done, run_last, "stream done on a non-final word")
    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, cmd_push, !q_full, "command pushed into full queue")

endmodule

[bench/lzss_ring_checker.sv]
// ----------------------------------------------------------------------------
// lzss_ring_checker
// Watches the register, input and output channels of the LZSS decompressor.
// Keeps its own copy of the history ring and the token parser, queues the
// two-byte words that each accepted input byte must produce, and compares
// every accepted output word field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module lzss_ring_checker
    import lzsd_pkg::*;
#(
    parameter int LEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             stream_start,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [7:0]       byte_first,
    input  logic [7:0]       byte_second,
    input  logic [1:0]       byte_count,
    input  logic             run_last,
    input  logic             stream_done,
    output int               fail_count,
    output int               expected_left,
    output int               words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        AWAIT_FLAG,
        AWAIT_TOKEN,
        AWAIT_MATCH_HI
    } parse_e;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
        logic [1:0] count;
        logic       last;
        logic       done;
    } out_word_t;

    logic [7:0]          history [WINDOW_SIZE];
    logic [WIN_BITS-1:0] wr_pos;
    logic [15:0]         flags;
    parse_e              phase;
    logic [7:0]          off_lo;
    logic [LEN_W-1:0]    remaining;
    logic [LEN_W-1:0]    cfg_len;
    logic [WIN_BITS-1:0] cfg_wstart;
    out_word_t           expected_words [$];
    logic [7:0]          fresh_bytes [$];
    int                  errors;
    int                  checked;

    task automatic push_history(input logic [7:0] v);
        history[wr_pos] = v;
        wr_pos = wr_pos + 1'b1;
        remaining = remaining - 1'b1;
        fresh_bytes.push_back(v);
    endtask

    task automatic next_token();
        flags = flags >> 1;
        phase = flags[8] ? AWAIT_TOKEN : AWAIT_FLAG;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [WIN_BITS-1:0] src;
        logic [WIN_BITS-1:0] rd;
        int                  span;
        int                  n;
        int                  k;
        out_word_t           w;
        if (!rst_n)
        begin
            for (k = 0; k < WINDOW_SIZE; k++)
                history[k] = '0;
            cfg_len    = '0;
            cfg_wstart = WINDOW_START_RESET;
            wr_pos     = WINDOW_START_RESET;
            flags      = '0;
            phase      = AWAIT_FLAG;
            off_lo     = '0;
            remaining  = '0;
            errors     = 0;
            checked    = 0;
            expected_words.delete();
            fail_count    <= 0;
            expected_left <= 0;
            words_seen    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_OUTPUT_LENGTH)
                    cfg_len = cfg_data;
                else if (cfg_index == REG_WINDOW_START)
                    cfg_wstart = cfg_data[WIN_BITS-1:0];
            end

            if (in_valid && in_ready)
            begin
                fresh_bytes.delete();
                if (stream_start)
                begin
                    for (k = 0; k < WINDOW_SIZE; k++)
                        history[k] = '0;
                    wr_pos    = cfg_wstart;
                    flags     = '0;
                    phase     = AWAIT_FLAG;
                    off_lo    = '0;
                    remaining = cfg_len;
                end
                if (remaining != '0)
                begin
                    case (phase)
                        AWAIT_TOKEN:
                        begin
                            if (flags[0])
                            begin
                                push_history(in_byte);
                                if (remaining != '0)
                                    next_token();
                            end
                            else
                            begin
                                off_lo = in_byte;
                                phase  = AWAIT_MATCH_HI;
                            end
                        end
                        AWAIT_MATCH_HI:
                        begin
                            src  = {in_byte[7:6], off_lo};
                            span = int'(in_byte[5:0]) + int'(MATCH_LEN_BIAS);
                            if (span > remaining)
                                span = int'(remaining);
                            for (k = 0; k < span; k++)
                            begin
                                rd = src + WIN_BITS'(k);
                                push_history(history[rd]);
                            end
                            if (remaining != '0)
                                next_token();
                        end
                        default:
                        begin
                            flags = {FLAG_FILL, in_byte};
                            phase = AWAIT_TOKEN;
                        end
                    endcase
                end
                n = fresh_bytes.size();
                for (k = 0; k < n; k += 2)
                begin
                    w.lead  = fresh_bytes[k];
                    w.trail = (k + 1 < n) ? fresh_bytes[k + 1] : 8'h00;
                    w.count = (k + 1 < n) ? 2'd2 : 2'd1;
                    w.last  = (k + 2 >= n);
                    w.done  = w.last && (remaining == '0);
                    expected_words.push_back(w);
                end
            end

            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: word not expected, expected none, actual 0x%0h 0x%0h n=%0d",
                             $time, byte_first, byte_second, byte_count);
                end
                else
                begin
                    w = expected_words.pop_front();
                    check_field("byte_first", w.lead, byte_first);
                    check_field("byte_second", w.trail, byte_second);
                    check_field("byte_count", w.count, byte_count);
                    check_field("run_last", w.last, run_last);
                    check_field("stream_done", w.done, stream_done);
                end
            end

            fail_count    <= errors;
            expected_left <= expected_words.size();
            words_seen    <= checked;
        end
    end

endmodule

[bench/tb_lzss_ring_decompressor.sv]
// ----------------------------------------------------------------------------
// tb_lzss_ring_decompressor
// Stimulus and verdict for the LZSS ring decompressor.
// A short directed part walks the idle and finished states, a zero and a
// one-byte output length, overlapping copies across the ring wrap and a cut
// match; then well-formed streams with random tokens run under a range of
// register settings, with random stalls on both channels and one long hold
// on the output that backs the block up. A checker module does the compare.
// ----------------------------------------------------------------------------
module tb_lzss_ring_decompressor;
    import lzsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LEN_W          = 24;
    localparam int         RANDOM_ITEMS   = 100;
    localparam int         SETTLE_CYCLES  = 300;
    localparam int         LONG_HOLD      = 400;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       in_byte;
    logic             stream_start;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [LEN_W-1:0] cfg_data;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       byte_first;
    logic [7:0]       byte_second;
    logic [1:0]       byte_count;
    logic             run_last;
    logic             stream_done;

    int               fail_count;
    int               expected_left;
    int               words_seen;
    int               items_sent    = 0;
    int               streams_begun = 0;
    int               idle_cycles   = 0;
    int               stall_req     = 0;
    logic             quiet         = 1'b0;
    logic [9:0]       cur_wstart    = WINDOW_START_RESET;

    lzss_ring_decompressor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .stream_start (stream_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_first   (byte_first),
        .byte_second  (byte_second),
        .byte_count   (byte_count),
        .run_last     (run_last),
        .stream_done  (stream_done)
    );

    lzss_ring_checker #(.LEN_W(LEN_W)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .stream_start  (stream_start),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_first    (byte_first),
        .byte_second   (byte_second),
        .byte_count    (byte_count),
        .run_last      (run_last),
        .stream_done   (stream_done),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .words_seen    (words_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : receiver
        int served;
        served = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_req != served)
            begin
                served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic offer_byte(input logic [7:0] b, input logic st);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        stream_start <= st;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (st)
            streams_begun++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic emit_stream(input int tokens, input int lit_pct, input logic long_runs);
        logic [7:0] flag_bits;
        logic [9:0] src;
        int         t;
        int         j;
        int         made;
        int         back_gap;
        int         len_code;
        made = 0;
        for (t = 0; t < tokens; t++)
        begin
            if (t % 8 == 0)
            begin
                for (j = 0; j < 8; j++)
                    flag_bits[j] = ($urandom_range(0, 99) < lit_pct);
                offer_byte(flag_bits, t == 0);
            end
            if (flag_bits[t % 8])
            begin
                offer_byte(8'($urandom), 1'b0);
                made++;
            end
            else
            begin
                len_code = long_runs ? $urandom_range(0, 63) : $urandom_range(0, 7);
                if (made == 0 || $urandom_range(0, 7) == 0)
                    src = 10'($urandom);
                else
                begin
                    back_gap = $urandom_range(1, (made < 1023) ? made : 1023);
                    src      = 10'(int'(cur_wstart) + made - back_gap);
                end
                offer_byte(src[7:0], 1'b0);
                offer_byte({src[9:8], len_code[5:0]}, 1'b0);
                made += len_code + 3;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [LEN_W-1:0] d;
        logic [9:0]       ws;
        int               phase_no;
        int               goal;
        int               n;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_byte      <= 8'h00;
        stream_start <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_OUTPUT_LENGTH;
        cfg_data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // idle after reset: dropped
        offer_byte(8'hAA, 1'b0);
        offer_byte(8'h55, 1'b0);
        settle();
        write_reg(REG_UNUSED, 24'hFFFFFF);
        write_reg(REG_OUTPUT_LENGTH, 24'd0);
        offer_byte(8'hFF, 1'b1);
        offer_byte(8'h01, 1'b0);

        // default window start, overlapping copy, match cut at the length
        settle();
        write_reg(REG_OUTPUT_LENGTH, 24'd40);
        offer_byte(8'hED, 1'b1);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'hBE, 1'b0);
        offer_byte(8'hC0, 1'b0);
        offer_byte(8'h80, 1'b0);
        offer_byte(8'h7F, 1'b0);
        offer_byte(8'hBE, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h12, 1'b0);

        // copy across the ring wrap, stream left mid-flag
        settle();
        write_reg(REG_WINDOW_START, 24'h0003FF);
        write_reg(REG_OUTPUT_LENGTH, 24'hFFFFFF);
        cur_wstart = 10'h3FF;
        offer_byte(8'h01, 1'b1);
        offer_byte(8'hC3, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'hC1, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h00, 1'b0);

        // one-byte stream, upper data bits masked off
        settle();
        write_reg(REG_WINDOW_START, 24'hFFFC00);
        write_reg(REG_OUTPUT_LENGTH, 24'd1);
        cur_wstart = 10'h000;
        offer_byte(8'hFF, 1'b1);
        offer_byte(8'hA5, 1'b0);
        offer_byte(8'h5A, 1'b0);

        phase_no = 0;
        goal     = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            settle();
            if (goal - items_sent < 40)
                quiet <= 1'b1;
            if (phase_no == 0)
                d = '1;
            else
            begin
                case ($urandom_range(0, 5))
                    0:       d = '1;
                    1:       d = LEN_W'($urandom_range(1, 8));
                    default: d = LEN_W'($urandom_range(20, 250));
                endcase
            end
            write_reg(REG_OUTPUT_LENGTH, d);
            case ($urandom_range(0, 3))
                0:       ws = '0;
                1:       ws = '1;
                default: ws = 10'($urandom);
            endcase
            d       = LEN_W'($urandom);
            d[9:0]  = ws;
            cur_wstart = ws;
            write_reg(REG_WINDOW_START, d);
            if (phase_no == 0)
                stall_req <= stall_req + 1;
            n = $urandom_range(1, 2);
            repeat (n)
                emit_stream($urandom_range(4, 16),
                            (phase_no == 0) ? 10 : $urandom_range(10, 90),
                            phase_no == 0 || $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    offer_byte(8'($urandom), $urandom_range(0, 7) == 0);
            phase_no++;
        end
        settle();

        $display("Covered %0d compressed bytes in %0d streams under %0d register settings,",
                 items_sent, streams_begun, phase_no + 4);
        $display("including zero, one-byte and full lengths; %0d output words compared.",
                 words_seen);
        if (fail_count == 0 && expected_left == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/lzsd_pkg.sv
rtl/lzsd_front.sv
rtl/lzsd_fifo.sv
rtl/lzsd_back.sv
rtl/lzss_ring_decompressor.sv
bench/lzss_ring_checker.sv
bench/tb_lzss_ring_decompressor.sv
